// ----- hdl/vap_pkg.sv -----
// Package with shared types, constants and helper functions of the VCF allele count parser.
`timescale 1ns / 1ps
`default_nettype none
package vap_pkg;
	localparam int MAX_FIELDS = 32;
	localparam int COUNT_W = 32;
	localparam int FC_W = $clog2(MAX_FIELDS + 1);

	localparam logic KIND_FORMAT = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PIPE  = 8'h7C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [23:0] TOK_AD  = 24'h004441;
	localparam logic [23:0] TOK_RO  = 24'h004F52;
	localparam logic [23:0] TOK_AO  = 24'h004F41;
	localparam logic [23:0] TOK_DP4 = 24'h345044;

	localparam logic [1:0] KEY_AD  = 2'd0;
	localparam logic [1:0] KEY_RO  = 2'd1;
	localparam logic [1:0] KEY_AO  = 2'd2;
	localparam logic [1:0] KEY_DP4 = 2'd3;

	localparam logic [2:0] MM_START = 3'd0;
	localparam logic [2:0] MM_DOT   = 3'd1;
	localparam logic [2:0] MM_SEP   = 3'd2;
	localparam logic [2:0] MM_FULL  = 3'd3;
	localparam logic [2:0] MM_NONE  = 3'd4;

	localparam logic [1:0] PH_LEAD = 2'd0;
	localparam logic [1:0] PH_DIGS = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [FC_W-1:0] fcount_t;

	typedef enum logic [1:0] {
		ST_SAMPLE  = 2'd0,
		ST_FMT_OK  = 2'd1,
		ST_FMT_BAD = 2'd2
	} status_t;

	typedef struct packed {
		logic       kind;
		logic       has_char;
		logic [7:0] char_code;
		logic       last;
	} item_t;

	typedef struct packed {
		logic        valid;
		status_t     status;
		logic [31:0] ref_count;
		logic        ref_valid;
		logic [31:0] alt_count;
		logic        alt_valid;
	} result_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] key;
	} key_match_t;

	function automatic key_match_t match_key(input logic [23:0] chars, input logic [2:0] len);
		key_match_t m;
		m.hit = 1'b0;
		m.key = KEY_AD;
		if (len == 3'd2) begin
			if (chars == TOK_AD) begin
				m.hit = 1'b1;
				m.key = KEY_AD;
			end else if (chars == TOK_RO) begin
				m.hit = 1'b1;
				m.key = KEY_RO;
			end else if (chars == TOK_AO) begin
				m.hit = 1'b1;
				m.key = KEY_AO;
			end
		end else if (len == 3'd3) begin
			if (chars == TOK_DP4) begin
				m.hit = 1'b1;
				m.key = KEY_DP4;
			end
		end
		return m;
	endfunction
endpackage
`default_nettype wire

// ----- hdl/vap_stream_if.sv -----
// Stream interfaces for the input character word and the result word.
`timescale 1ns / 1ps
`default_nettype none
interface vap_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic       has_char;
	logic [7:0] char_code;
	logic       last;
	modport source (output valid, kind, has_char, char_code, last, input ready);
	modport sink (input valid, kind, has_char, char_code, last, output ready);
endinterface

interface vap_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] ref_count;
	logic        ref_valid;
	logic [31:0] alt_count;
	logic        alt_valid;
	modport source (output valid, status, ref_count, ref_valid, alt_count, alt_valid,
		input ready);
	modport sink (input valid, status, ref_count, ref_valid, alt_count, alt_valid,
		output ready);
endinterface
`default_nettype wire

// ----- hdl/vap_parse_core.sv -----
// Parser state and per-character update logic of the VCF allele count parser.
`timescale 1ns / 1ps
`default_nettype none
module vap_parse_core
	import vap_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	input  wire item_t   item,
	output result_t      res
);
	logic          active_q;
	logic          kind_q;
	fcount_t       fc_q, fc_d;
	logic [23:0]   tok_q, tok_d;
	logic [2:0]    len_q, len_d;
	fcount_t       pos_q [4];
	fcount_t       pos_d [4];
	logic [3:0]    found_q, found_d;
	logic [2:0]    sub_q, sub_d;
	count_t        val_q [8];
	count_t        val_d [8];
	logic [7:0]    nonempty_q, nonempty_d;
	logic [3:0]    dp4_part_q, dp4_part_d;
	logic [3:0]    seen_q, seen_d;
	logic [2:0]    mm_q, mm_d;
	logic [1:0]    ph_q, ph_d;

	logic          begin_str;
	key_match_t    km;
	logic [3:0]    key_here;
	logic          e_hit;
	logic [2:0]    e_idx;
	logic          splits;
	logic          is_digit;
	logic [COUNT_W+3:0] acc;
	count_t        acc_sat;
	logic [COUNT_W:0]   sum_ref, sum_alt;
	count_t        rc, ac;
	logic          rv, av;
	status_t       status;

	assign is_digit = (item.char_code >= CH_ZERO) && (item.char_code <= CH_NINE);

	always_comb begin
		begin_str = !active_q || (item.kind != kind_q);
		fc_d = fc_q;
		tok_d = tok_q;
		len_d = len_q;
		pos_d = pos_q;
		found_d = found_q;
		sub_d = sub_q;
		val_d = val_q;
		nonempty_d = nonempty_q;
		dp4_part_d = dp4_part_q;
		seen_d = seen_q;
		mm_d = mm_q;
		ph_d = ph_q;
		km = '0;
		key_here = '0;
		e_hit = 1'b0;
		e_idx = '0;
		splits = 1'b0;
		acc = '0;
		acc_sat = '0;
		if (begin_str) begin
			fc_d = '0;
			tok_d = '0;
			len_d = '0;
			sub_d = '0;
			ph_d = PH_LEAD;
			mm_d = MM_START;
			nonempty_d = '0;
			dp4_part_d = '0;
			seen_d = '0;
			for (int i = 0; i < 8; i++) val_d[i] = '0;
			if (item.kind == KIND_FORMAT) begin
				found_d = '0;
				for (int k = 0; k < 4; k++) pos_d[k] = '0;
			end
		end
		if (item.kind == KIND_FORMAT) begin
			if (item.has_char) begin
				if (item.char_code == CH_COLON) begin
					km = match_key(tok_d, len_d);
					if (km.hit && (fc_d < fcount_t'(MAX_FIELDS))) begin
						pos_d[km.key] = fc_d;
						found_d[km.key] = 1'b1;
					end
					tok_d = '0;
					len_d = '0;
					if (fc_d < fcount_t'(MAX_FIELDS)) fc_d = fc_d + 1'b1;
				end else begin
					case (len_d)
						3'd0: tok_d[7:0] = item.char_code;
						3'd1: tok_d[15:8] = item.char_code;
						3'd2: tok_d[23:16] = item.char_code;
						default: ;
					endcase
					if (len_d < 3'd4) len_d = len_d + 1'b1;
				end
			end
			if (item.last && (len_d != 3'd0)) begin
				km = match_key(tok_d, len_d);
				if (km.hit && (fc_d < fcount_t'(MAX_FIELDS))) begin
					pos_d[km.key] = fc_d;
					found_d[km.key] = 1'b1;
				end
				tok_d = '0;
				len_d = '0;
			end
		end else if (item.has_char) begin
			case (mm_d)
				MM_START: mm_d = (item.char_code == CH_DOT) ? MM_DOT : MM_NONE;
				MM_DOT: mm_d = ((item.char_code == CH_SLASH) || (item.char_code == CH_PIPE))
					? MM_SEP : MM_NONE;
				MM_SEP: mm_d = (item.char_code == CH_DOT) ? MM_FULL : MM_NONE;
				default: mm_d = MM_NONE;
			endcase
			for (int k = 0; k < 4; k++) key_here[k] = found_d[k] && (pos_d[k] == fc_d);
			seen_d = seen_d | key_here;
			if (item.char_code == CH_COLON) begin
				if (fc_d < fcount_t'(MAX_FIELDS)) fc_d = fc_d + 1'b1;
				sub_d = '0;
				ph_d = PH_LEAD;
			end else begin
				if (key_here[KEY_AD]) begin
					splits = 1'b1;
					if (sub_d < 3'd2) begin
						e_hit = 1'b1;
						e_idx = sub_d;
					end
				end else if (key_here[KEY_RO]) begin
					e_hit = 1'b1;
					e_idx = 3'd2;
				end else if (key_here[KEY_AO]) begin
					e_hit = 1'b1;
					e_idx = 3'd3;
				end else if (key_here[KEY_DP4]) begin
					splits = 1'b1;
					if (sub_d < 3'd4) begin
						e_hit = 1'b1;
						e_idx = {1'b1, sub_d[1:0]};
						dp4_part_d[sub_d[1:0]] = 1'b1;
					end
				end
				if (splits && (item.char_code == CH_COMMA)) begin
					if (sub_d < 3'd7) sub_d = sub_d + 1'b1;
					ph_d = PH_LEAD;
				end else if (e_hit) begin
					nonempty_d[e_idx] = 1'b1;
					acc = ({4'b0, val_d[e_idx]} << 3) + ({4'b0, val_d[e_idx]} << 1)
						+ (COUNT_W+4)'(item.char_code[3:0]);
					acc_sat = (acc[COUNT_W+3:COUNT_W] != 4'd0) ? '1 : acc[COUNT_W-1:0];
					case (ph_d)
						PH_LEAD: begin
							if (item.char_code == CH_SPACE) begin
								ph_d = PH_LEAD;
							end else if ((item.char_code == CH_PLUS) ||
								(item.char_code == CH_MINUS)) begin
								ph_d = PH_DIGS;
							end else if (is_digit) begin
								val_d[e_idx] = acc_sat;
								ph_d = PH_DIGS;
							end else begin
								ph_d = PH_DONE;
							end
						end
						PH_DIGS: begin
							if (is_digit) val_d[e_idx] = acc_sat;
							else ph_d = PH_DONE;
						end
						default: ;
					endcase
				end
			end
		end
	end

	always_comb begin
		sum_ref = {1'b0, val_d[4]} + {1'b0, val_d[5]};
		sum_alt = {1'b0, val_d[6]} + {1'b0, val_d[7]};
		rc = '0;
		ac = '0;
		rv = 1'b0;
		av = 1'b0;
		if ((mm_d == MM_DOT) || (mm_d == MM_FULL)) begin
			rv = 1'b0;
		end else if (found_d[KEY_AD] && seen_d[KEY_AD]) begin
			rv = nonempty_d[0];
			av = nonempty_d[1];
			rc = val_d[0];
			ac = val_d[1];
		end else if (found_d[KEY_RO] && found_d[KEY_AO] && seen_d[KEY_RO] && seen_d[KEY_AO]) begin
			rv = nonempty_d[2];
			av = nonempty_d[3];
			rc = val_d[2];
			ac = val_d[3];
		end else if (found_d[KEY_DP4] && seen_d[KEY_DP4]) begin
			rv = dp4_part_d[0] && dp4_part_d[1];
			av = dp4_part_d[2] && dp4_part_d[3];
			rc = sum_ref[COUNT_W] ? '1 : sum_ref[COUNT_W-1:0];
			ac = sum_alt[COUNT_W] ? '1 : sum_alt[COUNT_W-1:0];
		end
		if (!rv) rc = '0;
		if (!av) ac = '0;
		if (item.kind == KIND_FORMAT) begin
			status = (found_d[KEY_AD] || found_d[KEY_DP4] || (found_d[KEY_RO] && found_d[KEY_AO]))
				? ST_FMT_OK : ST_FMT_BAD;
		end else begin
			status = ST_SAMPLE;
		end
		res.valid = item_valid && item.last;
		res.status = status;
		res.ref_count = (item.kind == KIND_FORMAT) ? 32'd0 : 32'(rc);
		res.ref_valid = (item.kind == KIND_FORMAT) ? 1'b0 : rv;
		res.alt_count = (item.kind == KIND_FORMAT) ? 32'd0 : 32'(ac);
		res.alt_valid = (item.kind == KIND_FORMAT) ? 1'b0 : av;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			kind_q <= KIND_FORMAT;
			fc_q <= '0;
			tok_q <= '0;
			len_q <= '0;
			for (int k = 0; k < 4; k++) pos_q[k] <= '0;
			found_q <= '0;
			sub_q <= '0;
			for (int i = 0; i < 8; i++) val_q[i] <= '0;
			nonempty_q <= '0;
			dp4_part_q <= '0;
			seen_q <= '0;
			mm_q <= MM_START;
			ph_q <= PH_LEAD;
		end else if (item_valid) begin
			active_q <= !item.last;
			kind_q <= item.kind;
			fc_q <= fc_d;
			tok_q <= tok_d;
			len_q <= len_d;
			pos_q <= pos_d;
			found_q <= found_d;
			sub_q <= sub_d;
			val_q <= val_d;
			nonempty_q <= nonempty_d;
			dp4_part_q <= dp4_part_d;
			seen_q <= seen_d;
			mm_q <= mm_d;
			ph_q <= ph_d;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/vcf_allele_count_parser.sv -----
// Top level of the VCF allele count parser with input and result registers.
//
// Channel   Direction  Word
// in_ch     sink       kind, has_char, char_code, last
// out_ch    source     status, ref_count, ref_valid, alt_count, alt_valid
//
// A new character word is accepted every cycle while out_ch is not blocked.
// A result is registered in out_q once the last word of a string has passed item_s1 and the core.
// Reset clears all parser state and the valid flags of both register stages.
// A stalled result holds the pipeline, so input stops only while out_ch is blocked.
`timescale 1ns / 1ps
`default_nettype none
module vcf_allele_count_parser
	import vap_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	vap_in_if.sink    in_ch,
	vap_out_if.source out_ch
);
	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	assign advance = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.kind <= in_ch.kind;
			item_s1.has_char <= in_ch.has_char;
			item_s1.char_code <= in_ch.char_code;
			item_s1.last <= in_ch.last;
		end
	end

	vap_parse_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1 && advance),
		.item       (item_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) out_q <= res;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.status = out_q.status;
	assign out_ch.ref_count = out_q.ref_count;
	assign out_ch.ref_valid = out_q.ref_valid;
	assign out_ch.alt_count = out_q.alt_count;
	assign out_ch.alt_valid = out_q.alt_valid;

`ifndef SYNTH
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready && valid_s1 |-> !in_ch.ready)
		else $error("input accepted while pipeline is full");
	a_format_no_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.status != ST_SAMPLE) |->
		!out_ch.ref_valid && !out_ch.alt_valid &&
		(out_ch.ref_count == 32'd0) && (out_ch.alt_count == 32'd0))
		else $error("format result carries counts");
	a_na_ref_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ref_valid |-> out_ch.ref_count == 32'd0)
		else $error("missing ref count is not zero");
	a_na_alt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.alt_valid |-> out_ch.alt_count == 32'd0)
		else $error("missing alt count is not zero");
`endif
endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for the VCF allele count parser with its own parser model.
`timescale 1ns / 1ps
`default_nettype none
module testbench
	import vap_pkg::*;
();
	localparam int CYCLE_LIMIT = 400000;
	localparam int MISMATCH_SHOW = 10;

	typedef struct {
		status_t     status;
		logic [31:0] ref_count;
		logic        ref_valid;
		logic [31:0] alt_count;
		logic        alt_valid;
	} counts_t;

	logic clk;
	logic arst_n;
	vap_in_if in_ch();
	vap_out_if out_ch();

	vcf_allele_count_parser i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	item_t pending_words[$];
	counts_t expected_counts[$];
	int mismatches = 0;
	int cycles = 0;
	bit stimulus_done = 0;

	// Parser state mirrored for prediction.
	bit p_active = 1'b0;
	logic p_kind = KIND_FORMAT;
	int p_field;
	logic [23:0] p_tok;
	int p_toklen;
	int p_keypos[4];
	logic [3:0] p_found = '0;
	int p_sub;
	logic [31:0] p_vals[8];
	logic [15:0] p_flags;
	int p_miss;
	int p_phase;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void start_string(logic kind);
		p_field = 0;
		p_tok = '0;
		p_toklen = 0;
		p_sub = 0;
		p_phase = PH_LEAD;
		p_miss = MM_START;
		p_flags = '0;
		for (int k = 0; k < 8; k++) p_vals[k] = '0;
		if (kind == KIND_FORMAT) begin
			p_found = '0;
			for (int k = 0; k < 4; k++) p_keypos[k] = 0;
		end
	endfunction

	function automatic void close_token();
		int key;
		key = 4;
		if (p_toklen == 2) begin
			if (p_tok == TOK_AD) key = KEY_AD;
			else if (p_tok == TOK_RO) key = KEY_RO;
			else if (p_tok == TOK_AO) key = KEY_AO;
		end else if (p_toklen == 3 && p_tok == TOK_DP4) begin
			key = KEY_DP4;
		end
		if (key < 4 && p_field < MAX_FIELDS) begin
			p_keypos[key] = p_field;
			p_found[key] = 1'b1;
		end
		p_tok = '0;
		p_toklen = 0;
	endfunction

	function automatic bit key_here(int k, int f);
		return p_found[k] && p_keypos[k] == f;
	endfunction

	function automatic void add_digit(int e, logic [7:0] c);
		logic [32:0] v;
		v = p_vals[e] * 33'd10 + (c - CH_ZERO);
		p_vals[e] = (p_vals[e] > (32'hFFFFFFFF - (c - CH_ZERO)) / 10) ? 32'hFFFFFFFF : v[31:0];
	endfunction

	function automatic void number_char(int e, logic [7:0] c);
		bit digit;
		digit = c >= CH_ZERO && c <= CH_NINE;
		if (p_phase == PH_LEAD) begin
			if (c == CH_SPACE) return;
			if (c == CH_PLUS || c == CH_MINUS) p_phase = PH_DIGS;
			else if (digit) begin
				add_digit(e, c);
				p_phase = PH_DIGS;
			end else p_phase = PH_DONE;
		end else if (p_phase == PH_DIGS) begin
			if (digit) add_digit(e, c);
			else p_phase = PH_DONE;
		end
	endfunction

	function automatic void sample_char(logic [7:0] c);
		int e;
		bit splits;
		e = 8;
		splits = 0;
		case (p_miss)
			MM_START: p_miss = (c == CH_DOT) ? MM_DOT : MM_NONE;
			MM_DOT: p_miss = (c == CH_SLASH || c == CH_PIPE) ? MM_SEP : MM_NONE;
			MM_SEP: p_miss = (c == CH_DOT) ? MM_FULL : MM_NONE;
			default: p_miss = MM_NONE;
		endcase
		for (int k = 0; k < 4; k++) if (key_here(k, p_field)) p_flags[12 + k] = 1'b1;
		if (c == CH_COLON) begin
			if (p_field < MAX_FIELDS) p_field++;
			p_sub = 0;
			p_phase = PH_LEAD;
			return;
		end
		if (key_here(KEY_AD, p_field)) begin
			splits = 1;
			if (p_sub < 2) e = p_sub;
		end else if (key_here(KEY_RO, p_field)) e = 2;
		else if (key_here(KEY_AO, p_field)) e = 3;
		else if (key_here(KEY_DP4, p_field)) begin
			splits = 1;
			if (p_sub < 4) begin
				e = 4 + p_sub;
				p_flags[8 + p_sub] = 1'b1;
			end
		end
		if (splits && c == CH_COMMA) begin
			if (p_sub < 7) p_sub++;
			p_phase = PH_LEAD;
			return;
		end
		if (e < 8) begin
			p_flags[e] = 1'b1;
			number_char(e, c);
		end
	endfunction

	function automatic logic [31:0] sum_sat(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = a + b;
		return s[32] ? 32'hFFFFFFFF : s[31:0];
	endfunction

	function automatic void predict_counts(item_t w);
		counts_t r;
		if (!p_active || w.kind != p_kind) start_string(w.kind);
		p_active = 1;
		p_kind = w.kind;
		r = '{ST_SAMPLE, '0, 1'b0, '0, 1'b0};
		if (w.kind == KIND_FORMAT) begin
			if (w.has_char) begin
				if (w.char_code == CH_COLON) begin
					close_token();
					if (p_field < MAX_FIELDS) p_field++;
				end else begin
					if (p_toklen < 3) p_tok[8 * p_toklen +: 8] = w.char_code;
					if (p_toklen < 4) p_toklen++;
				end
			end
			if (!w.last) return;
			if (p_toklen > 0) close_token();
			r.status = (p_found[KEY_AD] || p_found[KEY_DP4] || (p_found[KEY_RO] && p_found[KEY_AO]))
				? ST_FMT_OK : ST_FMT_BAD;
		end else begin
			if (w.has_char) sample_char(w.char_code);
			if (!w.last) return;
			if (p_miss != MM_DOT && p_miss != MM_FULL) begin
				if (p_found[KEY_AD] && p_flags[12]) begin
					r.ref_valid = p_flags[0];
					r.alt_valid = p_flags[1];
					r.ref_count = p_vals[0];
					r.alt_count = p_vals[1];
				end else if (p_found[KEY_RO] && p_found[KEY_AO] && p_flags[13] && p_flags[14]) begin
					r.ref_valid = p_flags[2];
					r.alt_valid = p_flags[3];
					r.ref_count = p_vals[2];
					r.alt_count = p_vals[3];
				end else if (p_found[KEY_DP4] && p_flags[15]) begin
					r.ref_valid = p_flags[8] & p_flags[9];
					r.alt_valid = p_flags[10] & p_flags[11];
					r.ref_count = sum_sat(p_vals[4], p_vals[5]);
					r.alt_count = sum_sat(p_vals[6], p_vals[7]);
				end
			end
			if (!r.ref_valid) r.ref_count = '0;
			if (!r.alt_valid) r.alt_count = '0;
		end
		p_active = 0;
		expected_counts.insert(expected_counts.size(), r);
	endfunction

	task automatic queue_text(logic kind, string s, bit empty_end);
		item_t w;
		for (int i = 0; i < s.len(); i++) begin
			w.kind = kind;
			w.has_char = 1'b1;
			w.char_code = s[i];
			w.last = (i == s.len() - 1) && !empty_end;
			pending_words.insert(pending_words.size(), w);
		end
		if (empty_end || s.len() == 0) begin
			w.kind = kind;
			w.has_char = 1'b0;
			w.char_code = 8'($urandom);
			w.last = 1'b1;
			pending_words.insert(pending_words.size(), w);
		end
	endtask

	function automatic string pick_name();
		case ($urandom_range(0, 9))
			0, 1: return "AD";
			2: return "RO";
			3: return "AO";
			4, 5: return "DP4";
			6: return "GT";
			7: return "DP";
			8: return "ADX";
			default: return "A";
		endcase
	endfunction

	function automatic string pick_number();
		string s;
		int n;
		s = "";
		case ($urandom_range(0, 9))
			0: return "";
			1: return "4294967295";
			2: return "99999999999";
			3: s = " ";
			4: s = "-";
			5: s = "+";
			default: ;
		endcase
		n = $urandom_range(1, 5);
		for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
		if ($urandom_range(0, 7) == 0) s = {s, ".5e3"};
		return s;
	endfunction

	function automatic string pick_sample();
		string s;
		int nf;
		int np;
		case ($urandom_range(0, 19))
			0: return ".";
			1: return "./.";
			2: return ".|.";
			3: begin
				s = "";
				for (int i = 0; i < $urandom_range(1, 8); i++)
					s = {s, string'(8'($urandom_range(0, 255)))};
				return s;
			end
			default: ;
		endcase
		s = "";
		nf = $urandom_range(1, 6);
		for (int f = 0; f < nf; f++) begin
			if (f > 0) s = {s, ":"};
			np = $urandom_range(1, 5);
			for (int p = 0; p < np; p++) begin
				if (p > 0) s = {s, ","};
				s = {s, pick_number()};
			end
		end
		return s;
	endfunction

	initial begin
		string fmt;
		int nf;
		item_t w;
		queue_text(KIND_SAMPLE, "1,2", 0);
		queue_text(KIND_FORMAT, "GT:AD:DP", 0);
		queue_text(KIND_SAMPLE, "0/1:4294967295,99999999999:7", 0);
		queue_text(KIND_SAMPLE, "./.", 0);
		queue_text(KIND_SAMPLE, ".", 1);
		queue_text(KIND_FORMAT, "RO:AO", 1);
		queue_text(KIND_SAMPLE, " +12.5:-3x", 0);
		queue_text(KIND_FORMAT, "DP4:GT", 0);
		queue_text(KIND_SAMPLE, "4294967295,1,,3:x", 0);
		queue_text(KIND_SAMPLE, "1,2,3", 0);
		queue_text(KIND_FORMAT, "GT:DPX:ADD", 0);
		queue_text(KIND_SAMPLE, ".|.", 0);
		queue_text(KIND_FORMAT, "", 0);
		w = '{KIND_FORMAT, 1'b1, 8'hFF, 1'b0};
		pending_words.insert(pending_words.size(), w);
		queue_text(KIND_SAMPLE, "\377\000", 0);
		fmt = "";
		for (int i = 0; i < 40; i++) fmt = {fmt, "X:"};
		queue_text(KIND_FORMAT, {fmt, "AD"}, 0);
		while (pending_words.size() < 1800) begin
			fmt = "";
			nf = $urandom_range(1, 5);
			for (int i = 0; i < nf; i++) fmt = {fmt, (i > 0) ? ":" : "", pick_name()};
			queue_text(KIND_FORMAT, fmt, $urandom_range(0, 5) == 0);
			for (int i = 0; i < $urandom_range(1, 6); i++)
				queue_text(KIND_SAMPLE, pick_sample(), $urandom_range(0, 5) == 0);
		end
		stimulus_done = 1;
	end

	task automatic w_drive(item_t w);
		in_ch.valid <= 1'b1;
		in_ch.kind <= w.kind;
		in_ch.has_char <= w.has_char;
		in_ch.char_code <= w.char_code;
		in_ch.last <= w.last;
	endtask

	int send_wait;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.kind <= 1'b0;
			in_ch.has_char <= 1'b0;
			in_ch.char_code <= '0;
			in_ch.last <= 1'b0;
			send_wait <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_counts('{in_ch.kind, in_ch.has_char, in_ch.char_code, in_ch.last});
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_wait > 0) begin
					in_ch.valid <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (pending_words.size() > 0) begin
					w_drive(pending_words.pop_front());
					send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	int stall;
	always @(posedge clk or negedge arst_n) begin
		counts_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_counts.size() == 0) begin
					mismatches++;
					if (mismatches <= MISMATCH_SHOW)
						$display("Unexpected result word: status %0d", out_ch.status);
				end else begin
					e = expected_counts.pop_front();
					if (out_ch.status !== e.status || out_ch.ref_count !== e.ref_count ||
						out_ch.ref_valid !== e.ref_valid || out_ch.alt_count !== e.alt_count ||
						out_ch.alt_valid !== e.alt_valid) begin
						mismatches++;
						if (mismatches <= MISMATCH_SHOW)
							$display("Mismatch: expected %0d %0d/%0b %0d/%0b, got %0d %0d/%0b %0d/%0b",
								e.status, e.ref_count, e.ref_valid, e.alt_count, e.alt_valid,
								out_ch.status, out_ch.ref_count, out_ch.ref_valid,
								out_ch.alt_count, out_ch.alt_valid);
					end
				end
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				stall <= stall - 1;
			end else begin
				out_ch.ready <= 1'b1;
				stall <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (stimulus_done);
		while (pending_words.size() > 0 || in_ch.valid) @(posedge clk);
		while (expected_counts.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_counts.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire
